FILE: design/vlq_pkg.sv
// Package: shared types and constants of the MIDI variable-length quantity codec.
`timescale 1ns / 1ps
package vlq_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int GROUP_BITS     = 7;
	localparam int OUT_VALUE_W    = 32;
	localparam int IN_VALUE_W     = 32;
	localparam logic [7:0] CONT_BIT   = 8'h80;
	localparam logic [7:0] GROUP_MASK = 8'h7F;
	localparam logic [7:0] COUNT_MAX  = 8'hFF;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_VALUE = 1'b1
	} kind_t;

	// Decoder outcome for one byte.
	typedef struct packed {
		logic                   emit;
		logic [OUT_VALUE_W-1:0] value;
		logic [7:0]             count;
	} dec_res_t;

endpackage

FILE: design/vlq_ifs.sv
// Interfaces: input and result channels of the codec.
`timescale 1ns / 1ps
interface vlq_in_if import vlq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	op_t                   opcode;
	logic [IN_VALUE_W-1:0] in_value;
	logic [7:0]            in_byte;

	modport source (output valid, output opcode, output in_value, output in_byte, input ready);
	modport sink (input valid, input opcode, input in_value, input in_byte, output ready);
endinterface

interface vlq_out_if import vlq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	kind_t                  kind;
	logic [7:0]             out_byte;
	logic [OUT_VALUE_W-1:0] out_value;
	logic [7:0]             byte_count;
	logic                   last;

	modport source (output valid, output kind, output out_byte, output out_value,
		output byte_count, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input out_value,
		input byte_count, input last, output ready);
endinterface

FILE: design/vlq_dec.sv
// Decoder state: accumulator and byte count, with the outcome of the current byte.
`timescale 1ns / 1ps
module vlq_dec import vlq_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	output dec_res_t   res
);

	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] acc_shift;
	logic [7:0]            cnt_q;
	logic                  cont;

	assign cont = (in_byte & CONT_BIT) != 8'h00;

	generate
		if (VALUE_BITS > GROUP_BITS) begin : g_shift
			assign acc_shift = {acc_q[VALUE_BITS-GROUP_BITS-1:0], in_byte[GROUP_BITS-1:0]};
		end else begin : g_only
			assign acc_shift = in_byte[GROUP_BITS-1:0];
		end
		if (VALUE_BITS >= OUT_VALUE_W) begin : g_trunc
			assign res.value = acc_shift[OUT_VALUE_W-1:0];
		end else begin : g_ext
			assign res.value = OUT_VALUE_W'(acc_shift);
		end
	endgenerate

	assign res.emit  = !cont;
	assign res.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= 8'd1;
		end else if (take) begin
			if (cont) begin
				acc_q <= acc_shift;
				// saturate the count
				if (cnt_q != COUNT_MAX) begin
					cnt_q <= cnt_q + 8'd1;
				end
			end else begin
				acc_q <= '0;
				cnt_q <= 8'd1;
			end
		end
	end

endmodule

FILE: design/vlq_ser.sv
// Result register: cuts encode values into groups; one item per cycle while ready.
`timescale 1ns / 1ps
module vlq_ser import vlq_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  op_t                       op,
	input  logic [(VALUE_BITS < IN_VALUE_W ? VALUE_BITS : IN_VALUE_W)-1:0] value,
	input  dec_res_t                  dec,
	output logic                      ready,
	vlq_out_if.source                 out_ch
);

	localparam int ENC_BITS   = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
	localparam int ENC_GROUPS = (ENC_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int IDX_W      = (ENC_GROUPS > 1) ? $clog2(ENC_GROUPS) : 1;

	logic [ENC_GROUPS*GROUP_BITS-1:0] vpad;
	logic [GROUP_BITS-1:0]            grp [ENC_GROUPS];
	logic [IDX_W-1:0]                 top;

	logic                   busy_q;
	kind_t                  kind_q;
	logic [GROUP_BITS-1:0]  groups_q [ENC_GROUPS];
	logic [IDX_W-1:0]       idx_q;
	logic [OUT_VALUE_W-1:0] value_q;
	logic [7:0]             count_q;
	logic                   last;

	always_comb begin
		vpad = '0;
		vpad[ENC_BITS-1:0] = value;
	end

	// find the highest nonzero group; zero still sends one byte
	always_comb begin
		top = '0;
		for (int i = 0; i < ENC_GROUPS; i++) begin
			grp[i] = vpad[i*GROUP_BITS +: GROUP_BITS];
			if (grp[i] != '0) begin
				top = IDX_W'(i);
			end
		end
	end

	assign last  = (idx_q == '0);
	assign ready = !busy_q || (out_ch.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= KIND_BYTE;
			idx_q  <= '0;
		end else if (load) begin
			if (op == OP_ENCODE) begin
				busy_q <= 1'b1;
				kind_q <= KIND_BYTE;
				idx_q  <= top;
			end else begin
				// a continuation byte leaves no result
				busy_q <= dec.emit;
				kind_q <= KIND_VALUE;
				idx_q  <= '0;
			end
		end else if (busy_q && out_ch.ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < ENC_GROUPS; i++) begin
				groups_q[i] <= grp[i];
			end
			value_q <= dec.value;
			count_q <= dec.count;
		end
	end

	assign out_ch.valid      = busy_q;
	assign out_ch.kind       = kind_q;
	assign out_ch.last       = last;
	assign out_ch.out_byte   = (kind_q == KIND_VALUE) ? 8'h00 : {!last, groups_q[idx_q]};
	assign out_ch.out_value  = (kind_q == KIND_VALUE) ? value_q : '0;
	assign out_ch.byte_count = (kind_q == KIND_VALUE) ? count_q : 8'h00;

	a_dec_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == KIND_VALUE |-> idx_q == '0)
		else $error("decoded value held with groups pending");
	a_hold_idx: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_ch.ready |=> busy_q && $stable(idx_q))
		else $error("pending group lost during stall");

endmodule

FILE: design/midi_vlq_codec_top.sv
// Top level of the MIDI variable-length quantity codec.
//
// Channels: in_ch takes items with valid/ready; opcode encode cuts in_value into
// 7-bit groups, opcode decode takes one byte of a stream in in_byte. out_ch
// gives result items with valid/ready; last marks the final result of an item.
// An encode item gives one to five byte results, most significant group first,
// with bit 7 set on all but the last. A decode byte with bit 7 set gives no
// result; one without it gives the accumulated value and its byte count.
// Each item passes the input register, then the result register. Throughput:
// one decode byte per cycle while out_ch is ready; an encode item holds the
// result register until out_ch has taken its last byte, as the single output
// byte lane sends one byte at a time, so the next item waits in the input register.
// Reset empties both stages, clears the accumulator and sets the count to one.
// When out_ch stalls, the result register holds its item, the input register
// keeps one more item, and in_ch.ready then drops until out_ch moves.
`timescale 1ns / 1ps
module midi_vlq_codec_top import vlq_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	vlq_in_if.sink   in_ch,
	vlq_out_if.source out_ch
);

	localparam int ENC_BITS = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

	logic                in_fire;
	logic                ser_ready;
	logic                ser_load;
	dec_res_t            dec_res;
	logic                valid_s1;
	op_t                 op_s1;
	logic [ENC_BITS-1:0] value_s1;
	dec_res_t            dec_s1;

	assign in_fire     = in_ch.valid && in_ch.ready;
	assign ser_load    = valid_s1 && ser_ready;
	assign in_ch.ready = !valid_s1 || ser_ready;

	vlq_dec #(.VALUE_BITS(VALUE_BITS)) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_fire && in_ch.opcode == OP_DECODE),
		.in_byte (in_ch.in_byte),
		.res     (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (ser_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= in_ch.opcode;
			value_s1 <= in_ch.in_value[ENC_BITS-1:0];
			dec_s1   <= dec_res;
		end
	end

	vlq_ser #(.VALUE_BITS(VALUE_BITS)) u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ser_load),
		.op     (op_s1),
		.value  (value_s1),
		.dec    (dec_s1),
		.ready  (ser_ready),
		.out_ch (out_ch)
	);

	a_value_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_VALUE |-> out_ch.last)
		else $error("decoded value not marked last");
	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_BYTE |-> out_ch.out_byte[7] == !out_ch.last)
		else $error("continuation bit disagrees with last");
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_VALUE |-> out_ch.byte_count != 8'h00)
		else $error("decoded value with zero byte count");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ser_ready |=> valid_s1 && $stable(op_s1) && $stable(value_s1))
		else $error("input register changed while stalled");

endmodule
